// File: rtl/pidsc_pkg.sv
// ---------------------------------------------------------------------------
// PID speed controller package
// Shared widths, register map codes and stage-to-stage structs.
// ---------------------------------------------------------------------------
package pidsc_pkg;

    // Field and datapath widths (signed Q8.8 unless noted)
    localparam int GAIN_W  = 16;
    localparam int SPEED_W = 16;
    localparam int DRIVE_W = 16;
    localparam int ERR_W   = SPEED_W + 1;      // target - measured, exact
    localparam int ACC_W   = 11;               // holds -512 .. 512
    localparam int DERR_W  = ERR_W + 1;        // error - previous error
    localparam int PK_W    = GAIN_W + ERR_W;   // kp * error
    localparam int PI_W    = GAIN_W + ACC_W;   // ki * accumulator
    localparam int PD_W    = GAIN_W + DERR_W;  // kd * error delta
    localparam int SUM_W   = PD_W + 2;         // three-term sum
    localparam int FRAC_W  = 8;                // Q8.8 fraction bits

    // Integral clamp bound, +-2.0
    localparam int ACC_LIMIT = 512;

    // Configuration port
    localparam int APB_DW = 32;
    localparam int ADDR_W = 4;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_KP = 2'd0;
    localparam logic [IDX_W-1:0] REG_KI = 2'd1;
    localparam logic [IDX_W-1:0] REG_KD = 2'd2;

    // Gain set handed from the register block to the datapath
    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } t_gains;

    // Partial products passed from the error logic to the output stage
    typedef struct packed {
        logic signed [PK_W-1:0] p;
        logic signed [PI_W-1:0] i;
        logic signed [PD_W-1:0] d;
    } t_products;

endpackage

// File: rtl/pidsc_cfg_regs.sv
// ---------------------------------------------------------------------------
// PID gain registers
// APB-style write/read access to the kp, ki and kd gain registers.
// ---------------------------------------------------------------------------
module pidsc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pidsc_pkg::ADDR_W-1:0]  paddr,
    input  logic [pidsc_pkg::APB_DW-1:0]  pwdata,
    output logic [pidsc_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    output pidsc_pkg::t_gains             o_gains
);
    import pidsc_pkg::*;

    t_gains             r_gains;
    logic               w_wr;
    logic [IDX_W-1:0]   w_idx;

    assign pready  = 1'b1;
    assign w_wr    = psel && penable && pwrite;
    assign w_idx   = paddr[ADDR_W-1:2];
    assign o_gains = r_gains;

    // Register write; unmapped index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_KP:  r_gains.kp <= pwdata[GAIN_W-1:0];
                REG_KI:  r_gains.ki <= pwdata[GAIN_W-1:0];
                REG_KD:  r_gains.kd <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back, sign-extended to the bus width
    always_comb begin
        unique case (w_idx)
            REG_KP:  prdata = APB_DW'(r_gains.kp);
            REG_KI:  prdata = APB_DW'(r_gains.ki);
            REG_KD:  prdata = APB_DW'(r_gains.kd);
            default: prdata = '0;
        endcase
    end

endmodule

// File: rtl/pidsc_core.sv
// ---------------------------------------------------------------------------
// PID error and product logic
// Input register, error/integral/derivative state and the three gain
// multiplies, fed straight into the output stage.
// ---------------------------------------------------------------------------
module pidsc_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pidsc_pkg::t_gains                    i_gains,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_enable,
    input  logic signed [pidsc_pkg::SPEED_W-1:0] i_measured_speed,
    input  logic signed [pidsc_pkg::SPEED_W-1:0] i_target_speed,
    output logic                                 o_prod_valid,
    input  logic                                 i_prod_ready,
    output pidsc_pkg::t_products                 o_products
);
    import pidsc_pkg::*;

    localparam logic signed [ERR_W:0] ACC_HI = (ERR_W+1)'(ACC_LIMIT);
    localparam logic signed [ERR_W:0] ACC_LO = (ERR_W+1)'(-ACC_LIMIT);

    // Input register
    logic                       r_in_valid;
    logic                       r_enable;
    logic signed [SPEED_W-1:0]  r_meas;
    logic signed [SPEED_W-1:0]  r_targ;

    // Controller state
    logic signed [ERR_W-1:0]    r_prev_err;
    logic signed [ACC_W-1:0]    r_acc;

    logic                       w_adv_in;
    logic signed [ERR_W-1:0]    w_err;
    logic signed [ERR_W:0]      w_acc_sum;
    logic signed [ACC_W-1:0]    n_acc;
    logic signed [DERR_W-1:0]   w_derr;
    t_products                  n_prod;

    // Input register loads when it is empty or its transaction moves on
    assign w_adv_in     = r_in_valid && i_prod_ready;
    assign o_ready      = !r_in_valid || i_prod_ready;
    assign o_prod_valid = r_in_valid;
    assign o_products   = n_prod;

    // Error, clamped integral and derivative terms
    always_comb begin
        w_err     = ERR_W'(r_targ) - ERR_W'(r_meas);
        w_acc_sum = (ERR_W+1)'(r_acc) + (ERR_W+1)'(w_err);
        w_derr    = DERR_W'(w_err) - DERR_W'(r_prev_err);
        priority if (w_acc_sum > ACC_HI) begin
            n_acc = ACC_W'(ACC_LIMIT);
        end else if (w_acc_sum < ACC_LO) begin
            n_acc = ACC_W'(-ACC_LIMIT);
        end else begin
            n_acc = w_acc_sum[ACC_W-1:0];
        end
    end

    // Gain multiplies; a disabled transaction yields zero products
    always_comb begin
        if (r_enable) begin
            n_prod.p = PK_W'(i_gains.kp) * PK_W'(w_err);
            n_prod.i = PI_W'(i_gains.ki) * PI_W'(n_acc);
            n_prod.d = PD_W'(i_gains.kd) * PD_W'(w_derr);
        end else begin
            n_prod = '0;
        end
    end

    // Input register capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_enable <= i_enable;
            r_meas   <= i_measured_speed;
            r_targ   <= i_target_speed;
        end
    end

    // State update, once per transaction as it leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_acc      <= '0;
        end else if (w_adv_in) begin
            if (r_enable) begin
                r_prev_err <= w_err;
                r_acc      <= n_acc;
            end else begin
                r_prev_err <= '0;
                r_acc      <= '0;
            end
        end
    end

endmodule

// File: rtl/pidsc_out_stage.sv
// ---------------------------------------------------------------------------
// PID output stage
// Sums the three products, scales back to Q8.8 with floor rounding,
// saturates to 16 bits and holds the result in the output register.
// ---------------------------------------------------------------------------
module pidsc_out_stage (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_prod_valid,
    output logic                                 o_prod_ready,
    input  pidsc_pkg::t_products                 i_products,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [pidsc_pkg::DRIVE_W-1:0] o_drive
);
    import pidsc_pkg::*;

    localparam logic signed [SUM_W-1:0] DRV_MAX = SUM_W'(2**(DRIVE_W-1) - 1);
    localparam logic signed [SUM_W-1:0] DRV_MIN = SUM_W'(-(2**(DRIVE_W-1)));

    logic                       r_valid;
    logic signed [DRIVE_W-1:0]  r_drive;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [SUM_W-1:0]    w_scaled;
    logic signed [DRIVE_W-1:0]  n_drive;

    assign o_prod_ready = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_drive      = r_drive;

    // Sum, arithmetic shift (floor), saturate
    always_comb begin
        w_sum    = SUM_W'(i_products.p) + SUM_W'(i_products.i) + SUM_W'(i_products.d);
        w_scaled = w_sum >>> FRAC_W;
        priority if (w_scaled > DRV_MAX) begin
            n_drive = DRV_MAX[DRIVE_W-1:0];
        end else if (w_scaled < DRV_MIN) begin
            n_drive = DRV_MIN[DRIVE_W-1:0];
        end else begin
            n_drive = w_scaled[DRIVE_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_prod_ready) begin
            r_valid <= i_prod_valid;
        end
        if (o_prod_ready && i_prod_valid) begin
            r_drive <= n_drive;
        end
    end

endmodule

// File: rtl/pid_speed_controller_unit.sv
// ---------------------------------------------------------------------------
// PID speed controller, top level
// Path: a taken input transaction passes through the input register, then
//   the output register, before o_valid rises.
// Throughput: one transaction per cycle; two transactions held under stall.
// Reset (synchronous, active low): gains, previous error, integral and all
//   stage valids clear to zero.
// ---------------------------------------------------------------------------
module pid_speed_controller_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pidsc_pkg::ADDR_W-1:0]         paddr,
    input  logic [pidsc_pkg::APB_DW-1:0]         pwdata,
    output logic [pidsc_pkg::APB_DW-1:0]         prdata,
    output logic                                 pready,
    // sample input
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_enable,
    input  logic signed [pidsc_pkg::SPEED_W-1:0] i_measured_speed,
    input  logic signed [pidsc_pkg::SPEED_W-1:0] i_target_speed,
    // drive output
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [pidsc_pkg::DRIVE_W-1:0] o_drive
);
    import pidsc_pkg::*;

    t_gains     w_gains;
    t_products  w_products;
    logic       w_prod_valid;
    logic       w_prod_ready;

    // Gain registers
    pidsc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gains (w_gains)
    );

    // Error state and multiplies
    pidsc_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_gains          (w_gains),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_enable         (i_enable),
        .i_measured_speed (i_measured_speed),
        .i_target_speed   (i_target_speed),
        .o_prod_valid     (w_prod_valid),
        .i_prod_ready     (w_prod_ready),
        .o_products       (w_products)
    );

    // Sum, scale, saturate
    pidsc_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_prod_valid (w_prod_valid),
        .o_prod_ready (w_prod_ready),
        .i_products   (w_products),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_drive      (o_drive)
    );

endmodule
